@@ src/qtr_pkg.sv @@
// Package for the quadtree raster fill block: item kinds, register map,
// reset values and the cursor command struct. No dependencies.
`default_nettype none

package qtr_pkg;

    localparam int GRID_SIDE_DEF = 128;

    localparam int KIND_W  = 2;
    localparam int DIGIT_W = 2;
    localparam int PIX_W   = 7;
    localparam int CFG_W   = 8;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    localparam logic CFG_IDX_ROWS = 1'b0;
    localparam logic CFG_IDX_COLS = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_DIGIT = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef struct packed {
        logic               step;
        logic [DIGIT_W-1:0] digit;
        logic               restart;
    } t_cur_cmd;

endpackage

`default_nettype wire

@@ src/qtr_if.sv @@
// Handshake interfaces for the request and response channels.
// Depends on qtr_pkg for field widths.
`default_nettype none

interface qtr_in_if
    import qtr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [DIGIT_W-1:0] digit;
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_col;

    modport source (output valid, kind, digit, pixel_row, pixel_col, input ready);
    modport sink (input valid, kind, digit, pixel_row, pixel_col, output ready);
endinterface

interface qtr_out_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, pixel, input ready);
    modport sink (input valid, pixel, output ready);
endinterface

`default_nettype wire

@@ src/qtr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module qtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

@@ src/qtr_cursor.sv @@
// Configuration registers on the APB port and the quadtree cursor block.
// Depends on qtr_pkg.
`default_nettype none

module qtr_cursor
    import qtr_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    localparam int SIDE_W  = $clog2(GRID_SIDE + 1),
    localparam int COORD_W = $clog2(GRID_SIDE)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready,
    input  wire t_cur_cmd            i_cmd,
    output logic      [COORD_W-1:0]  o_cur_row,
    output logic      [COORD_W-1:0]  o_cur_col,
    output logic      [SIDE_W-1:0]   o_bsize
);
    localparam int SIDE_MAX = 1 << ($clog2(GRID_SIDE + 1) - 1);

    logic [CFG_W-1:0]   r_rows, r_cols, n_rows, n_cols;
    logic [COORD_W-1:0] r_cur_row, r_cur_col;
    logic [SIDE_W-1:0]  r_bsize, w_half;
    logic               w_wr, w_idx;

    function automatic logic [SIDE_W-1:0] f_side(input logic [CFG_W-1:0] a,
                                                 input logic [CFG_W-1:0] b);
        int need;
        int res;
        need = (a > b) ? int'(a) : int'(b);
        if (need < 1) need = 1;
        if (need > GRID_SIDE) need = GRID_SIDE;
        res = SIDE_MAX;
        for (int k = SIDE_W - 1; k >= 0; k--) begin
            if ((1 << k) >= need && (1 << k) <= SIDE_MAX) res = 1 << k;
        end
        return SIDE_W'(res);
    endfunction

    assign pready = 1'b1;
    assign w_idx  = paddr[2];
    assign w_wr   = psel & penable & pwrite;
    assign prdata = (w_idx == CFG_IDX_COLS) ? APB_DW'(r_cols) : APB_DW'(r_rows);
    assign n_rows = (w_wr && w_idx == CFG_IDX_ROWS) ? pwdata[CFG_W-1:0] : r_rows;
    assign n_cols = (w_wr && w_idx == CFG_IDX_COLS) ? pwdata[CFG_W-1:0] : r_cols;
    assign w_half = r_bsize >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= CFG_RESET;
            r_cols    <= CFG_RESET;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_bsize   <= f_side(CFG_RESET, CFG_RESET);
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
            if (w_wr || i_cmd.restart) begin
                r_cur_row <= '0;
                r_cur_col <= '0;
                r_bsize   <= f_side(n_rows, n_cols);
            end else if (i_cmd.step && r_bsize > SIDE_W'(1)) begin
                if (i_cmd.digit[1]) r_cur_row <= r_cur_row + COORD_W'(w_half);
                if (i_cmd.digit[0]) r_cur_col <= r_cur_col + COORD_W'(w_half);
                r_bsize <= w_half;
            end
        end
    end

    assign o_cur_row = r_cur_row;
    assign o_cur_col = r_cur_col;
    assign o_bsize   = r_bsize;

    a_bsize_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_bsize)) else $error("block size is not a power of two");

    a_cursor_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SIDE_W + 1)'(r_cur_row) + (SIDE_W + 1)'(r_bsize) <= (SIDE_W + 1)'(SIDE_MAX))
        else $error("cursor block leaves the grid");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (r_cur_row == '0 && r_cur_col == '0))
        else $error("cursor not returned to the origin after a register write");
endmodule

`default_nettype wire

@@ src/qtr_engine.sv @@
// Sequencer that runs each transaction: cursor steps, row-by-row block fill
// through the bitmap RAM, pixel reads and clears. Depends on qtr_pkg, qtr_if.
`default_nettype none

module qtr_engine
    import qtr_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    localparam int SIDE_W  = $clog2(GRID_SIDE + 1),
    localparam int COORD_W = $clog2(GRID_SIDE)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    qtr_in_if.sink                    i_req,
    qtr_out_if.source                 o_rsp,
    input  wire logic [COORD_W-1:0]   i_cur_row,
    input  wire logic [COORD_W-1:0]   i_cur_col,
    input  wire logic [SIDE_W-1:0]    i_bsize,
    output t_cur_cmd                  o_cmd,
    output logic                      o_we,
    output logic      [COORD_W-1:0]   o_waddr,
    output logic      [GRID_SIDE-1:0] o_wdata,
    output logic                      o_re,
    output logic      [COORD_W-1:0]   o_raddr,
    input  wire logic [GRID_SIDE-1:0] i_rdata
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FILL = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [GRID_SIDE-1:0] r_row_valid, n_row_valid;
    logic [GRID_SIDE-1:0] r_mask, n_mask, w_mask;
    logic [COORD_W-1:0] r_row, n_row, r_wrow, n_wrow, r_rcol, n_rcol;
    logic [SIDE_W-1:0]  r_left, n_left;
    logic [SIDE_W:0]    w_end;
    logic               r_wpend, n_wpend, r_wvalid, n_wvalid;
    logic               r_out_valid, n_out_valid, r_pixel, n_pixel;
    logic               r_rin, n_rin, r_rvalid, n_rvalid;
    logic               w_take, w_take_clear, w_in_range;
    t_kind              w_kind;

    assign i_req.ready  = (r_state == S_IDLE);
    assign w_take       = i_req.valid & i_req.ready;
    assign w_kind       = t_kind'(i_req.kind);
    assign w_take_clear = w_take && (w_kind == KIND_CLEAR);
    assign w_in_range   = (32'(i_req.pixel_row) < GRID_SIDE) &&
                          (32'(i_req.pixel_col) < GRID_SIDE);
    assign w_end        = (SIDE_W + 1)'(i_cur_col) + (SIDE_W + 1)'(i_bsize);

    always_comb begin
        for (int i = 0; i < GRID_SIDE; i++) begin
            w_mask[i] = ((SIDE_W + 1)'(i) >= (SIDE_W + 1)'(i_cur_col)) &&
                        ((SIDE_W + 1)'(i) < w_end);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row_valid = r_row_valid;
        n_mask      = r_mask;
        n_row       = r_row;
        n_left      = r_left;
        n_wpend     = 1'b0;
        n_wrow      = r_wrow;
        n_wvalid    = r_wvalid;
        n_rcol      = r_rcol;
        n_rin       = r_rin;
        n_rvalid    = r_rvalid;
        n_pixel     = r_pixel;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        o_cmd       = '0;
        o_we        = 1'b0;
        o_waddr     = r_wrow;
        o_wdata     = (r_wvalid ? i_rdata : '0) | r_mask;
        o_re        = 1'b0;
        o_raddr     = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    unique case (w_kind)
                        KIND_DIGIT: begin
                            o_cmd.step  = 1'b1;
                            o_cmd.digit = i_req.digit;
                        end
                        KIND_FILL: begin
                            n_row         = i_cur_row;
                            n_left        = i_bsize;
                            n_mask        = w_mask;
                            o_cmd.restart = 1'b1;
                            n_state       = S_FILL;
                        end
                        KIND_READ: begin
                            o_re     = 1'b1;
                            o_raddr  = COORD_W'(i_req.pixel_row);
                            n_rin    = w_in_range;
                            n_rvalid = r_row_valid[COORD_W'(i_req.pixel_row)];
                            n_rcol   = COORD_W'(i_req.pixel_col);
                            n_state  = S_READ;
                        end
                        KIND_CLEAR: begin
                            n_row_valid = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (r_left != '0) begin
                    o_re     = 1'b1;
                    n_row    = r_row + COORD_W'(1);
                    n_left   = r_left - SIDE_W'(1);
                    n_wpend  = 1'b1;
                    n_wrow   = r_row;
                    n_wvalid = r_row_valid[r_row];
                end else begin
                    n_state = S_IDLE;
                end
                if (r_wpend) begin
                    o_we                = 1'b1;
                    n_row_valid[r_wrow] = 1'b1;
                end
            end
            S_READ: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_pixel     = r_rin & r_rvalid & i_rdata[r_rcol];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_valid <= '0;
            r_wpend     <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_wpend     <= n_wpend;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask   <= n_mask;
        r_row    <= n_row;
        r_wrow   <= n_wrow;
        r_wvalid <= n_wvalid;
        r_rcol   <= n_rcol;
        r_rin    <= n_rin;
        r_rvalid <= n_rvalid;
        r_pixel  <= n_pixel;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.pixel = r_pixel;

    a_rsp_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_READ))
        else $error("response raised outside a read");

    a_fill_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_left != '0 || r_wpend))
        else $error("fill sequencer stalled with no work");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_clear |=> (r_row_valid == '0))
        else $error("bitmap not cleared after clear transaction");
endmodule

`default_nettype wire

@@ src/quadtree_path_raster_fill_top.sv @@
// Top level of the region-quadtree path decoder that fills a square bitmap.
// Depends on qtr_pkg, qtr_if, qtr_ram, qtr_cursor and qtr_engine.
//
//   Channel  Direction  Handshake               Payload
//   i_req    in         valid/ready             kind, digit, pixel_row, pixel_col
//   o_rsp    out        valid/ready             pixel
//   APB      in         psel/penable/pready     paddr, pwdata, prdata
//
// Digit and clear transactions complete as they are accepted; a read also waits
// for the response register to drain.
// A fill writes one bitmap row per cycle, over block_size rows (up to GRID_SIDE),
// through the read-modify-write path of the single RAM port pair.
// Reset is synchronous and active low; it zeroes the row valid flags at once,
// so the bitmap reads as cleared with no clearing pass.
// A stalled response does not stop new transactions except a read.
`default_nettype none

module quadtree_path_raster_fill_top
    import qtr_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    qtr_in_if.sink                 i_req,
    qtr_out_if.source              o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);
    localparam int SIDE_W  = $clog2(GRID_SIDE + 1);
    localparam int COORD_W = $clog2(GRID_SIDE);

    t_cur_cmd             w_cmd;
    logic [COORD_W-1:0]   w_cur_row, w_cur_col, w_waddr, w_raddr;
    logic [SIDE_W-1:0]    w_bsize;
    logic                 w_we, w_re;
    logic [GRID_SIDE-1:0] w_wdata, w_rdata;

    qtr_cursor #(
        .GRID_SIDE (GRID_SIDE)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_cmd     (w_cmd),
        .o_cur_row (w_cur_row),
        .o_cur_col (w_cur_col),
        .o_bsize   (w_bsize)
    );

    qtr_engine #(
        .GRID_SIDE (GRID_SIDE)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_cur_row (w_cur_row),
        .i_cur_col (w_cur_col),
        .i_bsize   (w_bsize),
        .o_cmd     (w_cmd),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata),
        .o_re      (w_re),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata)
    );

    qtr_ram #(
        .WIDTH (GRID_SIDE),
        .DEPTH (GRID_SIDE)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );
endmodule

`default_nettype wire

@@ sim/qtr_pixel_checker.sv @@
// Checker for the quadtree raster fill block: watches the request, response
// and APB channels, keeps its own bitmap and cursor, and compares read data.
// Depends on qtr_pkg and the channel interfaces in qtr_if.
`timescale 1ns / 100ps

module qtr_pixel_checker
    import qtr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    qtr_in_if                 i_req,
    qtr_out_if                i_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_pending,
    output int                o_fail_count
);

    logic [GRID_SIDE_DEF-1:0] lit_rows [GRID_SIDE_DEF];
    logic [PIX_W-1:0]         cur_row;
    logic [PIX_W-1:0]         cur_col;
    logic [CFG_W-1:0]         cur_span;
    logic [CFG_W-1:0]         rows_reg;
    logic [CFG_W-1:0]         cols_reg;
    logic                     expected_pixels [$];
    int                       rsp_seen;

    function automatic logic [CFG_W-1:0] grid_span(input logic [CFG_W-1:0] rows,
                                                   input logic [CFG_W-1:0] cols);
        int need;
        int span;
        need = (rows > cols) ? int'(rows) : int'(cols);
        span = 1;
        if (need < 1) need = 1;
        if (need > GRID_SIDE_DEF) need = GRID_SIDE_DEF;
        while (span < need) span = span * 2;
        return span[CFG_W-1:0];
    endfunction

    task automatic restart_cursor();
        cur_row  = '0;
        cur_col  = '0;
        cur_span = grid_span(rows_reg, cols_reg);
    endtask

    task automatic report(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic apply_request(input logic [KIND_W-1:0] kind,
                                 input logic [DIGIT_W-1:0] digit,
                                 input logic [PIX_W-1:0] row,
                                 input logic [PIX_W-1:0] col);
        logic [CFG_W-1:0] half;
        case (t_kind'(kind))
            KIND_DIGIT: begin
                if (cur_span > 1) begin
                    half = cur_span >> 1;
                    if (digit[1]) cur_row = cur_row + half[PIX_W-1:0];
                    if (digit[0]) cur_col = cur_col + half[PIX_W-1:0];
                    cur_span = half;
                end
            end
            KIND_FILL: begin
                for (int r = 0; r < int'(cur_span); r++) begin
                    for (int c = 0; c < int'(cur_span); c++) begin
                        lit_rows[int'(cur_row) + r][int'(cur_col) + c] = 1'b1;
                    end
                end
                restart_cursor();
            end
            KIND_READ: begin
                expected_pixels.push_back(lit_rows[row][col]);
            end
            KIND_CLEAR: begin
                foreach (lit_rows[i]) lit_rows[i] = '0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            foreach (lit_rows[i]) lit_rows[i] = '0;
            rows_reg = CFG_RESET;
            cols_reg = CFG_RESET;
            restart_cursor();
            expected_pixels.delete();
            rsp_seen = 0;
            o_fail_count = 0;
        end else begin
            // Responses first, so a read accepted at this edge cannot match itself.
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_pixels.size() == 0) begin
                    report($sformatf("response transaction %0d with no read waiting",
                                     rsp_seen));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_rsp.pixel !== want) begin
                        report($sformatf("response transaction %0d: pixel %b, expected %b",
                                         rsp_seen, i_rsp.pixel, want));
                    end
                end
                rsp_seen++;
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.kind, i_req.digit, i_req.pixel_row, i_req.pixel_col);
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[APB_AW-1:2] == CFG_IDX_ROWS) begin
                    rows_reg = pwdata[CFG_W-1:0];
                    restart_cursor();
                end else if (paddr[APB_AW-1:2] == CFG_IDX_COLS) begin
                    cols_reg = pwdata[CFG_W-1:0];
                    restart_cursor();
                end
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for quadtree_path_raster_fill_top: clock, reset, request and
// APB stimulus, response back-pressure and the final verdict.
// Depends on qtr_pkg, qtr_if, the block's RTL and qtr_pixel_checker.
`timescale 1ns / 100ps

module tb;
    import qtr_pkg::*;

    localparam int FILL_SETTLE = 150;
    localparam int ITEM_GOAL   = 1450;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int pending_pixels;
    int fail_count;
    int item_count;
    int read_limit;
    bit src_idle_on;
    bit snk_idle_on;

    qtr_in_if  req_if ();
    qtr_out_if rsp_if ();

    quadtree_path_raster_fill_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qtr_pixel_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_pending    (pending_pixels),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_item(input t_kind kind, input logic [DIGIT_W-1:0] digit,
                             input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 63) == 0) src_idle_on = !src_idle_on;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.kind      <= kind;
        req_if.digit     <= digit;
        req_if.pixel_row <= row;
        req_if.pixel_col <= col;
        req_if.valid     <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        item_count++;
    endtask

    task automatic path_digit(input logic [DIGIT_W-1:0] digit);
        send_item(KIND_DIGIT, digit, PIX_W'($urandom_range(0, 127)),
                  PIX_W'($urandom_range(0, 127)));
    endtask

    task automatic fill_block();
        send_item(KIND_FILL, DIGIT_W'($urandom_range(0, 3)), PIX_W'($urandom_range(0, 127)),
                  PIX_W'($urandom_range(0, 127)));
    endtask

    task automatic read_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
        send_item(KIND_READ, DIGIT_W'($urandom_range(0, 3)), row, col);
    endtask

    task automatic clear_all();
        send_item(KIND_CLEAR, DIGIT_W'($urandom_range(0, 3)), PIX_W'($urandom_range(0, 127)),
                  PIX_W'($urandom_range(0, 127)));
    endtask

    function automatic logic [PIX_W-1:0] pick_coord();
        if ($urandom_range(0, 3) != 0) return PIX_W'($urandom_range(0, read_limit));
        return PIX_W'($urandom_range(0, 127));
    endfunction

    // Waits out outstanding reads and any fill still being written.
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels != 0);
        repeat (FILL_SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        int need;
        settle();
        apb_write(CFG_IDX_ROWS, rows);
        apb_write(CFG_IDX_COLS, cols);
        need = (rows > cols) ? int'(rows) : int'(cols);
        if (need < 1) need = 1;
        if (need > GRID_SIDE_DEF) need = GRID_SIDE_DEF;
        read_limit = need - 1;
    endtask

    // Mostly whole paths with random digits, ended by a fill; some paths are
    // abandoned, and reads, clears and arbitrary transactions are mixed in.
    task automatic run_phase(input int n_items);
        int start;
        int depth;
        int choice;
        start = item_count;
        while (item_count - start < n_items) begin
            choice = $urandom_range(0, 99);
            if (choice < 65) begin
                depth = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8)
                                                    : $urandom_range(4, 8);
                repeat (depth) begin
                    path_digit(DIGIT_W'($urandom_range(0, 3)));
                    if ($urandom_range(0, 4) == 0) read_pixel(pick_coord(), pick_coord());
                end
                if ($urandom_range(0, 9) != 0) fill_block();
            end else if (choice < 88) begin
                read_pixel(pick_coord(), pick_coord());
            end else if (choice < 93) begin
                clear_all();
            end else begin
                send_item(t_kind'($urandom_range(0, 3)), DIGIT_W'($urandom_range(0, 3)),
                          PIX_W'($urandom_range(0, 127)), PIX_W'($urandom_range(0, 127)));
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] geo_rows [10];
        logic [CFG_W-1:0] geo_cols [10];
        geo_rows = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd128, 8'd5, 8'd16, 8'd129, 8'd64, 8'd128};
        geo_cols = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd1, 8'd100, 8'd16, 8'd7, 8'd64, 8'd128};
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_if.valid     <= 1'b0;
        req_if.kind      <= '0;
        req_if.digit     <= '0;
        req_if.pixel_row <= '0;
        req_if.pixel_col <= '0;
        item_count  = 0;
        read_limit  = GRID_SIDE_DEF - 1;
        src_idle_on = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset geometry, a 128 by 128 grid.
        read_pixel(0, 0);
        read_pixel(127, 127);
        path_digit(0);
        fill_block();
        read_pixel(63, 63);
        read_pixel(64, 0);
        repeat (7) path_digit(3);
        path_digit(2);
        fill_block();
        read_pixel(127, 127);
        read_pixel(126, 127);
        path_digit(1);
        path_digit(2);
        clear_all();
        fill_block();
        read_pixel(32, 64);
        read_pixel(0, 0);
        fill_block();
        read_pixel(127, 0);

        foreach (geo_rows[i]) begin
            set_geometry(geo_rows[i], geo_cols[i]);
            run_phase(110);
        end
        while (item_count < ITEM_GOAL) begin
            set_geometry(CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(1, 128)),
                         CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(1, 128)));
            run_phase(150);
        end
        settle();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        snk_idle_on = 1'b1;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = snk_idle_on ? $urandom_range(0, 12) : 0;
            if ($urandom_range(0, 63) == 0) snk_idle_on = !snk_idle_on;
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    initial begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
